### design/crp_pkg.sv
// ----------------------------------------------------------------------------
// crp_pkg
// Types and constants shared by the completion ring purge block: field widths,
// operation codes, register map, controller states and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package crp_pkg;

    localparam int OP_W      = 2;
    localparam int SLOT_W    = 8;
    localparam int PAIR_W    = 24;
    localparam int TAG_W     = 32;
    localparam int DATA_W    = PAIR_W + TAG_W;
    localparam int FREED_W   = 8;
    localparam int POS_W     = 32;
    localparam int LOG_W     = 4;
    localparam int APB_DW    = 32;
    localparam int CFG_ADDR_W = 3;

    localparam logic [OP_W-1:0] OP_POST  = 2'd0;
    localparam logic [OP_W-1:0] OP_POLL  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAN = 2'd2;

    // register index taken from paddr[2]
    localparam logic REG_RING_LOG_SIZE = 1'b0;
    localparam logic [LOG_W-1:0] LOG_SIZE_RESET = 4'd8;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_POLL_RD,
        S_POLL_CHK,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SWEEP_RD,
        S_SWEEP_CHK,
        S_RELEASE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clr_wr;
        logic op_load;
        logic post_wr;
        logic rd_cons;
        logic poll_take;
        logic scan_rd;
        logic span_inc;
        logic sweep_init;
        logic sweep_rd;
        logic sweep_step;
        logic rel_wr;
        logic res_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic owner_hw;
        logic span_at_mask;
        logic span_zero;
        logic pair_match;
        logic k_last;
        logic freed_zero;
        logic rel_last;
        logic out_free;
    } t_dp_sts;

endpackage

### design/crp_in_if.sv
// ----------------------------------------------------------------------------
// crp_in_if
// Operation channel of the completion ring: valid/ready plus one operation word.
// ----------------------------------------------------------------------------
interface crp_in_if;
    import crp_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [SLOT_W-1:0] slot;
    logic [PAIR_W-1:0] pair_number;
    logic [TAG_W-1:0]  tag;

    modport source (output valid, output operation, output slot, output pair_number,
                    output tag, input ready);
    modport sink   (input valid, input operation, input slot, input pair_number,
                    input tag, output ready);
endinterface

### design/crp_out_if.sv
// ----------------------------------------------------------------------------
// crp_out_if
// Result channel of the completion ring: valid/ready plus one result word.
// ----------------------------------------------------------------------------
interface crp_out_if;
    import crp_pkg::*;

    logic               valid;
    logic               ready;
    logic               found;
    logic [PAIR_W-1:0]  out_pair_number;
    logic [TAG_W-1:0]   out_tag;
    logic [FREED_W-1:0] freed_count;
    logic [POS_W-1:0]   consumer_position;

    modport source (output valid, output found, output out_pair_number, output out_tag,
                    output freed_count, output consumer_position, input ready);
    modport sink   (input valid, input found, input out_pair_number, input out_tag,
                    input freed_count, input consumer_position, output ready);
endinterface

### design/crp_ctrl.sv
// ----------------------------------------------------------------------------
// crp_ctrl
// Sequencer for the completion ring: clearing pass, post, poll, and the
// clean operation (forward producer scan, backward sweep, slot release).
// ----------------------------------------------------------------------------
module crp_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [crp_pkg::OP_W-1:0] i_operation,
    input  crp_pkg::t_dp_sts         i_sts,
    output crp_pkg::t_dp_cmd         o_cmd
);
    import crp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.op_load = 1'b1;
                    unique case (i_operation)
                        OP_POST: begin
                            o_cmd.post_wr = 1'b1;
                            n_state       = S_DONE;
                        end
                        OP_POLL:  n_state = S_POLL_RD;
                        OP_CLEAN: n_state = S_SCAN_RD;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_POLL_RD: begin
                o_cmd.rd_cons = 1'b1;
                n_state       = S_POLL_CHK;
            end
            S_POLL_CHK: begin
                o_cmd.poll_take = !i_sts.owner_hw;
                n_state         = S_DONE;
            end
            S_SCAN_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state       = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (i_sts.owner_hw || i_sts.span_at_mask) begin
                    if (i_sts.span_zero) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.sweep_init = 1'b1;
                        n_state          = S_SWEEP_RD;
                    end
                end else begin
                    o_cmd.span_inc = 1'b1;
                    n_state        = S_SCAN_RD;
                end
            end
            S_SWEEP_RD: begin
                o_cmd.sweep_rd = 1'b1;
                n_state        = S_SWEEP_CHK;
            end
            S_SWEEP_CHK: begin
                o_cmd.sweep_step = 1'b1;
                if (!i_sts.k_last) begin
                    n_state = S_SWEEP_RD;
                end else if (i_sts.freed_zero && !i_sts.pair_match) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_RELEASE;
                end
            end
            S_RELEASE: begin
                o_cmd.rel_wr = 1'b1;
                if (i_sts.rel_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

### design/crp_dp.sv
// ----------------------------------------------------------------------------
// crp_dp
// Datapath of the completion ring: slot store (owner bits and entry data),
// consumer index, scan and sweep counters, and the result register.
// ----------------------------------------------------------------------------
module crp_dp #(
    parameter int RING_DEPTH = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  crp_pkg::t_dp_cmd                      i_cmd,
    output crp_pkg::t_dp_sts                      o_sts,
    input  logic [$clog2(RING_DEPTH)-1:0]         i_mask,
    input  logic [crp_pkg::SLOT_W-1:0]            i_slot,
    input  logic [crp_pkg::PAIR_W-1:0]            i_pair_number,
    input  logic [crp_pkg::TAG_W-1:0]             i_tag,
    crp_out_if.source                             o_rsp
);
    import crp_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);

    logic              r_owner_mem [RING_DEPTH];
    logic [DATA_W-1:0] r_data_mem  [RING_DEPTH];
    logic              r_owner_rd;
    logic [DATA_W-1:0] r_data_rd;

    logic [POS_W-1:0]  r_cons;
    logic [AW-1:0]     r_clr;
    logic [AW-1:0]     r_span;
    logic [AW-1:0]     r_k;
    logic [AW-1:0]     r_freed;
    logic [AW-1:0]     r_rel;
    logic [PAIR_W-1:0] r_pair;
    logic              r_found;
    logic [PAIR_W-1:0] r_res_pair;
    logic [TAG_W-1:0]  r_res_tag;

    logic               r_out_valid;
    logic               r_out_found;
    logic [PAIR_W-1:0]  r_out_pair;
    logic [TAG_W-1:0]   r_out_tag;
    logic [FREED_W-1:0] r_out_freed;
    logic [POS_W-1:0]   r_out_pos;

    logic [POS_W-1:0]  rd_sum;
    logic [POS_W-1:0]  src_pos;
    logic [POS_W-1:0]  dst_pos;
    logic [AW-1:0]     raddr;
    logic              rd_en;
    logic [AW-1:0]     cons_addr;
    logic [AW-1:0]     slot_addr;
    logic [AW-1:0]     dst_addr;
    logic [POS_W-1:0]  slot_ext;
    logic              owner_we;
    logic [AW-1:0]     owner_waddr;
    logic              owner_wdata;
    logic              data_we;
    logic [AW-1:0]     data_waddr;
    logic [DATA_W-1:0] data_wdata;
    logic              pair_match;
    logic [POS_W-1:0]  freed_ext;
    logic [FREED_W-1:0] freed_sat;

    assign slot_ext   = POS_W'(i_slot);
    assign slot_addr  = slot_ext[AW-1:0] & i_mask;
    assign cons_addr  = r_cons[AW-1:0] & i_mask;
    assign src_pos    = r_cons + POS_W'(r_k) - POS_W'(1);
    assign dst_pos    = src_pos + POS_W'(r_freed);
    assign dst_addr   = dst_pos[AW-1:0] & i_mask;
    assign pair_match = (r_data_rd[DATA_W-1:TAG_W] == r_pair);
    assign freed_ext  = POS_W'(r_freed);
    assign freed_sat  = (freed_ext > POS_W'(255)) ? '1 : freed_ext[FREED_W-1:0];
    assign rd_en      = i_cmd.rd_cons || i_cmd.scan_rd || i_cmd.sweep_rd;

    always_comb begin
        if (i_cmd.scan_rd) begin
            rd_sum = r_cons + POS_W'(r_span);
        end else if (i_cmd.sweep_rd) begin
            rd_sum = src_pos;
        end else begin
            rd_sum = r_cons;
        end
        raddr = rd_sum[AW-1:0] & i_mask;
    end

    // owner bit writes: clearing pass, post, poll hand-back, release after clean
    always_comb begin
        owner_we    = 1'b0;
        owner_waddr = cons_addr;
        owner_wdata = 1'b1;
        if (i_cmd.clr_wr) begin
            owner_we    = 1'b1;
            owner_waddr = r_clr;
        end else if (i_cmd.post_wr) begin
            owner_we    = 1'b1;
            owner_waddr = slot_addr;
            owner_wdata = 1'b0;
        end else if (i_cmd.poll_take || i_cmd.rel_wr) begin
            owner_we    = 1'b1;
        end
    end

    // entry data writes: post, or an older entry moved forward over a gap
    always_comb begin
        data_we    = 1'b0;
        data_waddr = slot_addr;
        data_wdata = {i_pair_number, i_tag};
        if (i_cmd.post_wr) begin
            data_we = 1'b1;
        end else if (i_cmd.sweep_step && !pair_match && (r_freed != '0)) begin
            data_we    = 1'b1;
            data_waddr = dst_addr;
            data_wdata = r_data_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (owner_we) begin
            r_owner_mem[owner_waddr] <= owner_wdata;
        end
        if (rd_en) begin
            r_owner_rd <= r_owner_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (data_we) begin
            r_data_mem[data_waddr] <= data_wdata;
        end
        if (rd_en) begin
            r_data_rd <= r_data_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cons      <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.poll_take || i_cmd.rel_wr) begin
                r_cons <= r_cons + POS_W'(1);
            end
            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op_load) begin
            r_pair     <= i_pair_number;
            r_found    <= 1'b0;
            r_res_pair <= '0;
            r_res_tag  <= '0;
            r_freed    <= '0;
            r_span     <= '0;
        end
        if (i_cmd.poll_take) begin
            r_found    <= 1'b1;
            r_res_pair <= r_data_rd[DATA_W-1:TAG_W];
            r_res_tag  <= r_data_rd[TAG_W-1:0];
        end
        if (i_cmd.span_inc) begin
            r_span <= r_span + AW'(1);
        end
        if (i_cmd.sweep_init) begin
            r_k   <= r_span;
            r_rel <= '0;
        end
        if (i_cmd.sweep_step) begin
            r_k <= r_k - AW'(1);
            if (pair_match) begin
                r_freed <= r_freed + AW'(1);
            end
        end
        if (i_cmd.rel_wr) begin
            r_rel <= r_rel + AW'(1);
        end
        if (i_cmd.res_load) begin
            r_out_found <= r_found;
            r_out_pair  <= r_res_pair;
            r_out_tag   <= r_res_tag;
            r_out_freed <= freed_sat;
            r_out_pos   <= r_cons;
        end
    end

    assign o_sts.clr_last     = (r_clr == AW'(RING_DEPTH - 1));
    assign o_sts.owner_hw     = r_owner_rd;
    assign o_sts.span_at_mask = (r_span == i_mask);
    assign o_sts.span_zero    = (r_span == '0);
    assign o_sts.pair_match   = pair_match;
    assign o_sts.k_last       = (r_k == AW'(1));
    assign o_sts.freed_zero   = (r_freed == '0);
    assign o_sts.rel_last     = ({1'b0, r_rel} + (AW+1)'(1)) == {1'b0, r_freed};
    assign o_sts.out_free     = !r_out_valid || o_rsp.ready;

    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.found             = r_out_found;
    assign o_rsp.out_pair_number   = r_out_pair;
    assign o_rsp.out_tag           = r_out_tag;
    assign o_rsp.freed_count       = r_out_freed;
    assign o_rsp.consumer_position = r_out_pos;

endmodule

### design/completion_ring_purge_core.sv
// ----------------------------------------------------------------------------
// completion_ring_purge_core
// Completion ring with owner bits: post, poll, and clean of one queue pair.
// One word in flight: a new operation is taken only in the idle state. The slot
// store has a registered read, so every slot access in poll, scan and sweep is a
// read state followed by a check state.
// After reset a clearing pass hands every slot to hardware.
// ----------------------------------------------------------------------------
module completion_ring_purge_core #(
    parameter int RING_DEPTH = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    crp_in_if.sink                           i_cmd,
    crp_out_if.source                        o_rsp,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [crp_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [crp_pkg::APB_DW-1:0]       pwdata,
    output logic [crp_pkg::APB_DW-1:0]       prdata,
    output logic                             pready
);
    import crp_pkg::*;

    localparam int AW      = $clog2(RING_DEPTH);
    localparam int LOG_MAX = $clog2(RING_DEPTH + 1) - 1;

    logic [LOG_W-1:0] r_log_size;
    logic             reg_idx;
    logic [4:0]       log_eff;
    logic [31:0]      mask_full;
    logic [AW-1:0]    mask;
    t_dp_cmd          cmd;
    t_dp_sts          sts;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log_size <= LOG_SIZE_RESET;
        end else if (psel && penable && pwrite && pready && (reg_idx == REG_RING_LOG_SIZE)) begin
            r_log_size <= pwdata[LOG_W-1:0];
        end
    end

    assign prdata = (reg_idx == REG_RING_LOG_SIZE) ? APB_DW'(r_log_size) : '0;

    // a zero size counts as one, and the ring never grows past the store
    always_comb begin
        log_eff = (r_log_size == '0) ? 5'd1 : 5'(r_log_size);
        if (log_eff > 5'(LOG_MAX)) begin
            log_eff = 5'(LOG_MAX);
        end
        mask_full = (32'd1 << log_eff) - 32'd1;
        mask      = mask_full[AW-1:0];
    end

    crp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_cmd.valid),
        .o_ready     (i_cmd.ready),
        .i_operation (i_cmd.operation),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    crp_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_mask        (mask),
        .i_slot        (i_cmd.slot),
        .i_pair_number (i_cmd.pair_number),
        .i_tag         (i_cmd.tag),
        .o_rsp         (o_rsp)
    );

endmodule
